// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is asserted
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("property violated");

// a stalled transfer keeps its valid and payload
`define ASSERT_HOLD(lbl, clk, rstn, vld, stl, data) \
  `ASSERT_RST(lbl, clk, rstn, vld && stl |=> vld && $stable(data))

`endif

// File: rtl/core/mrs_pkg.sv
// package for the meter record serializer: constants, control word types
// and the microcode table of the sequencer; no dependencies
`default_nettype none

package mrs_pkg;

  localparam int VolumeDigits = 8;
  localparam int VolBits      = 32;
  localparam int BcdW         = 4 * VolumeDigits;
  localparam int BcdBytes     = (VolumeDigits + 1) / 2;
  localparam int BcdPadW      = 8 * BcdBytes;
  localparam int CntW         = $clog2(VolBits);
  localparam int StepW        = 4;
  localparam int CfgIdxW      = 1;
  localparam int SupW         = 14;

  localparam logic [7:0] DifVolume   = 8'(8'h08 + BcdBytes);
  localparam logic [7:0] VifVolume   = 8'h13;
  localparam logic [7:0] DifInt16    = 8'h02;
  localparam logic [7:0] VifTemp     = 8'h66;
  localparam logic [7:0] VifExt      = 8'hFD;
  localparam logic [7:0] VifeMv      = 8'h46;
  localparam logic [SupW-1:0] FloorReset   = 14'd2500;
  localparam logic [SupW-1:0] CeilingReset = 14'd5600;

  localparam logic [CfgIdxW-1:0] CFG_FLOOR   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_CEILING = 1'd1;

  localparam logic [StepW-1:0] S_WAIT     = 4'd0;
  localparam logic [StepW-1:0] S_CONV     = 4'd1;
  localparam logic [StepW-1:0] S_VOL_DIF  = 4'd2;
  localparam logic [StepW-1:0] S_VOL_VIF  = 4'd3;
  localparam logic [StepW-1:0] S_VOL_BCD  = 4'd4;
  localparam logic [StepW-1:0] S_TMP_DIF  = 4'd5;
  localparam logic [StepW-1:0] S_TMP_VIF  = 4'd6;
  localparam logic [StepW-1:0] S_TMP_LO   = 4'd7;
  localparam logic [StepW-1:0] S_TMP_HI   = 4'd8;
  localparam logic [StepW-1:0] S_SUP_DIF  = 4'd9;
  localparam logic [StepW-1:0] S_SUP_VIF  = 4'd10;
  localparam logic [StepW-1:0] S_SUP_VIFE = 4'd11;
  localparam logic [StepW-1:0] S_SUP_LO   = 4'd12;
  localparam logic [StepW-1:0] S_SUP_HI   = 4'd13;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_CONV,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_BCD,
    SRC_TMP_LO,
    SRC_TMP_HI,
    SRC_SUP_LO,
    SRC_SUP_HI
  } src_e;

  typedef enum logic [1:0] {
    LIM_NONE,
    LIM_BITS,
    LIM_BYTES
  } lim_e;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_IF_EXCL
  } last_e;

  typedef struct packed {
    op_e              op;
    src_e             src;
    logic [7:0]       konst;
    lim_e             lim;
    last_e            last;
    logic [StepW-1:0] tgt;
  } ctrl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } conv_ctl_t;

  function automatic ctrl_t mrs_ucode(input logic [StepW-1:0] step);
    ctrl_t cw;
    cw = '{op: OP_WAIT, src: SRC_CONST, konst: 8'h00, lim: LIM_NONE,
           last: LAST_NO, tgt: S_WAIT};
    case (step)
      S_WAIT: begin
        cw.op = OP_WAIT;
      end
      S_CONV: begin
        cw.op  = OP_CONV;
        cw.lim = LIM_BITS;
      end
      S_VOL_DIF: begin
        cw.op    = OP_EMIT;
        cw.konst = DifVolume;
      end
      S_VOL_VIF: begin
        cw.op    = OP_EMIT;
        cw.konst = VifVolume;
      end
      S_VOL_BCD: begin
        cw.op  = OP_EMIT;
        cw.src = SRC_BCD;
        cw.lim = LIM_BYTES;
      end
      S_TMP_DIF: begin
        cw.op    = OP_EMIT;
        cw.konst = DifInt16;
      end
      S_TMP_VIF: begin
        cw.op    = OP_EMIT;
        cw.konst = VifTemp;
      end
      S_TMP_LO: begin
        cw.op  = OP_EMIT;
        cw.src = SRC_TMP_LO;
      end
      S_TMP_HI: begin
        cw.op   = OP_EMIT;
        cw.src  = SRC_TMP_HI;
        cw.last = LAST_IF_EXCL;
      end
      S_SUP_DIF: begin
        cw.op    = OP_EMIT;
        cw.konst = DifInt16;
      end
      S_SUP_VIF: begin
        cw.op    = OP_EMIT;
        cw.konst = VifExt;
      end
      S_SUP_VIFE: begin
        cw.op    = OP_EMIT;
        cw.konst = VifeMv;
      end
      S_SUP_LO: begin
        cw.op  = OP_EMIT;
        cw.src = SRC_SUP_LO;
      end
      S_SUP_HI: begin
        cw.op   = OP_EMIT;
        cw.src  = SRC_SUP_HI;
        cw.last = LAST_YES;
      end
      default: begin
        cw.op = OP_WAIT;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mrs_bcd_conv.sv
// shift-and-add-3 binary to bcd converter, one input bit per cycle while ctl_i.shift is set
// depends on mrs_pkg
`default_nettype none

module mrs_bcd_conv import mrs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire conv_ctl_t            ctl_i,
  input  wire logic [VolBits-1:0]   bin_i,
  output logic      [BcdW-1:0]      bcd_o
);

  logic [VolBits-1:0] bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [BcdW-1:0]    adj;

  always_comb begin
    for (int d = 0; d < VolumeDigits; d++) begin
      if (bcd_q[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = 4'(bcd_q[4*d +: 4] + 4'd3);
      end else begin
        adj[4*d +: 4] = bcd_q[4*d +: 4];
      end
    end
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (ctl_i.load) begin
      bin_d = bin_i;
      bcd_d = '0;
    end else if (ctl_i.shift) begin
      bin_d = {bin_q[VolBits-2:0], 1'b0};
      bcd_d = {adj[BcdW-2:0], bin_q[VolBits-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign bcd_o = bcd_q;

endmodule

`default_nettype wire

// File: rtl/core/meter_record_serializer.sv
// top level of the meter record serializer: microcoded sequencer,
// held reading, limit registers and output register
// depends on mrs_pkg and mrs_bcd_conv
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//   in       in         in_valid_i / in_stall_o volume, temperature, supply
//   out      out        out_valid_o / out_stall_i record_byte_o, last_byte_o
//
// one reading is accepted, converted to bcd bit-serially and then sent
// at one byte per cycle while the output is not stalled: 10 bytes without
// the supply record, 15 with it
// the output register holds one byte; a stall on it pauses the sequencer
// reset clears the sequencer and loads the default supply limits
`default_nettype none

module meter_record_serializer import mrs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [SupW-1:0]      cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [VolBits-1:0]   volume_litres_i,
  input  wire logic signed [15:0]   temperature_tenths_i,
  input  wire logic [SupW-1:0]      supply_millivolts_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                record_byte_o,
  output logic                      last_byte_o
);

  logic [SupW-1:0]  floor_q, ceil_q;
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [15:0]      tmp_q;
  logic [SupW-1:0]  sup_q;
  logic             incl_q;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;

  ctrl_t            cw;
  conv_ctl_t        conv_ctl;
  logic [BcdW-1:0]  bcd;
  logic [BcdPadW-1:0] bcd_pad;
  logic [7:0]       bcd_byte;
  logic [7:0]       sel_byte;
  logic             in_xfer, out_free, emit, lim_hit, is_last, step_done;

  assign cw         = mrs_ucode(step_q);
  assign in_stall_o = (cw.op != OP_WAIT);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = (cw.op == OP_EMIT) && out_free;

  assign conv_ctl.load  = in_xfer;
  assign conv_ctl.shift = (cw.op == OP_CONV);

  mrs_bcd_conv u_conv (
    .clk_i (clk_i),
    .ctl_i (conv_ctl),
    .bin_i (volume_litres_i),
    .bcd_o (bcd)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FloorReset;
      ceil_q  <= CeilingReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FLOOR:   floor_q <= cfg_wdata_i;
        CFG_CEILING: ceil_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // held reading
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tmp_q  <= $unsigned(temperature_tenths_i);
      sup_q  <= supply_millivolts_i;
      incl_q <= (supply_millivolts_i > floor_q) && (supply_millivolts_i < ceil_q);
    end
  end

  assign bcd_pad = BcdPadW'(bcd);

  always_comb begin
    bcd_byte = '0;
    for (int i = 0; i < BcdBytes; i++) begin
      if (cnt_q == CntW'(i)) begin
        bcd_byte = bcd_pad[8*i +: 8];
      end
    end
  end

  always_comb begin
    case (cw.src)
      SRC_CONST:  sel_byte = cw.konst;
      SRC_BCD:    sel_byte = bcd_byte;
      SRC_TMP_LO: sel_byte = tmp_q[7:0];
      SRC_TMP_HI: sel_byte = tmp_q[15:8];
      SRC_SUP_LO: sel_byte = sup_q[7:0];
      SRC_SUP_HI: sel_byte = 8'({2'b00, sup_q[SupW-1:8]});
      default:    sel_byte = cw.konst;
    endcase
  end

  always_comb begin
    case (cw.lim)
      LIM_BITS:  lim_hit = (cnt_q == CntW'(VolBits - 1));
      LIM_BYTES: lim_hit = (cnt_q == CntW'(BcdBytes - 1));
      default:   lim_hit = 1'b1;
    endcase
    case (cw.last)
      LAST_YES:     is_last = 1'b1;
      LAST_IF_EXCL: is_last = !incl_q;
      default:      is_last = 1'b0;
    endcase
    case (cw.op)
      OP_WAIT: step_done = in_xfer;
      OP_CONV: step_done = 1'b1;
      OP_EMIT: step_done = emit;
      default: step_done = 1'b0;
    endcase
  end

  // step counter and loop counter
  always_comb begin
    step_d = step_q;
    cnt_d  = cnt_q;
    if (step_done) begin
      if (!lim_hit) begin
        cnt_d = CntW'(cnt_q + 1'b1);
      end else begin
        cnt_d  = '0;
        step_d = is_last ? cw.tgt : StepW'(step_q + 1'b1);
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      out_last_d  = is_last;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_WAIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign record_byte_o = out_byte_q;
  assign last_byte_o   = out_last_q;

endmodule

`default_nettype wire

// File: rtl/core/mrs_checker.sv
// port-level checker for the meter record serializer and its bind
// depends on assert_macros.svh and meter_record_serializer
`default_nettype none
`include "assert_macros.svh"

module mrs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] record_byte_o,
  input wire logic       last_byte_o
);

  logic [8:0] out_pay;

  assign out_pay = {last_byte_o, record_byte_o};

  // stalled output transfer holds
  `ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_stall_i, out_pay)

  // an accepted reading makes the block busy
  `ASSERT_RST(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)

  // the block frees up only right after the last byte of a reading
  `ASSERT_RST(a_free_after_last, clk_i, rst_ni, $fell(in_stall_o) |-> out_valid_o && last_byte_o)

endmodule

bind meter_record_serializer mrs_checker u_mrs_checker (.*);

`default_nettype wire

// File: dv/tb_meter_record_serializer.sv
// self-checking testbench for meter_record_serializer: a directed table, then random
// readings over several supply limit settings, each byte checked against typed bytes or a local encoder
// depends on mrs_pkg and the rtl of meter_record_serializer
`default_nettype none

module tb_meter_record_serializer;

  timeunit 1ns;
  timeprecision 1ps;

  import mrs_pkg::*;

  localparam logic [7:0] DIF_VOL_BCD   = 8'h0C;
  localparam logic [7:0] VIF_VOL_LITRE = 8'h13;
  localparam logic [7:0] DIF_WORD      = 8'h02;
  localparam logic [7:0] VIF_TEMP      = 8'h66;
  localparam logic [7:0] VIF_EXT       = 8'hFD;
  localparam logic [7:0] VIFE_MV       = 8'h46;
  localparam int NUM_DIRECTED = 10;
  localparam int NUM_SETTINGS = 9;
  localparam int PER_SETTING  = 11;

  typedef struct packed {
    logic [31:0]  vol;
    logic [15:0]  temp;
    logic [13:0]  sup;
    logic [3:0]   n_typed;
    logic [119:0] typed;
  } reading_row_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } record_byte_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_FLOOR;
  logic [SupW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [31:0]       volume_litres_i = '0;
  logic signed [15:0] temperature_tenths_i = '0;
  logic [SupW-1:0]   supply_millivolts_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        record_byte_o;
  logic              last_byte_o;

  record_byte_t pending_bytes [$];
  reading_row_t directed_rows [NUM_DIRECTED];
  logic [13:0]  floor_set [NUM_SETTINGS];
  logic [13:0]  ceiling_set [NUM_SETTINGS];
  logic [13:0]  floor_mv = 14'd2500;
  logic [13:0]  ceiling_mv = 14'd5600;
  logic         quiet = 1'b0;
  int           error_count = 0;
  int           readings_sent = 0;
  int           bytes_seen = 0;
  int           supply_records = 0;

  meter_record_serializer u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .volume_litres_i      (volume_litres_i),
    .temperature_tenths_i (temperature_tenths_i),
    .supply_millivolts_i  (supply_millivolts_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .record_byte_o        (record_byte_o),
    .last_byte_o          (last_byte_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic void queue_byte(input logic [7:0] value, input logic last);
    record_byte_t slot;
    slot.value = value;
    slot.last  = last;
    pending_bytes.push_back(slot);
  endfunction

  // byte stream of one reading under the current limits
  function automatic void encode_reading(input logic [31:0] vol, input logic [15:0] temp,
                                         input logic [13:0] sup);
    logic [31:0] rest;
    logic [31:0] digits;
    logic        with_supply;
    rest   = vol % 32'd100000000;
    digits = '0;
    for (int d = 0; d < 8; d++) begin
      digits[4*d +: 4] = 4'(rest % 32'd10);
      rest = rest / 32'd10;
    end
    with_supply = (sup > floor_mv) && (sup < ceiling_mv);
    queue_byte(DIF_VOL_BCD, 1'b0);
    queue_byte(VIF_VOL_LITRE, 1'b0);
    for (int b = 0; b < 4; b++) queue_byte(digits[8*b +: 8], 1'b0);
    queue_byte(DIF_WORD, 1'b0);
    queue_byte(VIF_TEMP, 1'b0);
    queue_byte(temp[7:0], 1'b0);
    queue_byte(temp[15:8], !with_supply);
    if (with_supply) begin
      queue_byte(DIF_WORD, 1'b0);
      queue_byte(VIF_EXT, 1'b0);
      queue_byte(VIFE_MV, 1'b0);
      queue_byte(sup[7:0], 1'b0);
      queue_byte({2'b00, sup[13:8]}, 1'b1);
      supply_records++;
    end
  endfunction

  task automatic send_reading(input reading_row_t row);
    while (!quiet && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    volume_litres_i      <= row.vol;
    temperature_tenths_i <= row.temp;
    supply_millivolts_i  <= row.sup;
    do @(posedge clk_i); while (in_stall_o);
    if (row.n_typed != 0) begin
      for (int k = 0; k < row.n_typed; k++) begin
        queue_byte(row.typed[119 - 8*k -: 8], k == row.n_typed - 1);
      end
      if (row.n_typed == 15) supply_records++;
    end else begin
      encode_reading(row.vol, row.temp, row.sup);
    end
    readings_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [13:0] fl, input logic [13:0] cl);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_FLOOR;
    cfg_wdata_i <= fl;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CEILING;
    cfg_wdata_i <= cl;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    floor_mv    = fl;
    ceiling_mv  = cl;
  endtask

  always @(posedge clk_i) begin
    record_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h last %0b", record_byte_o, last_byte_o));
      end else begin
        want = pending_bytes.pop_front();
        if (record_byte_o !== want.value || last_byte_o !== want.last) begin
          flag_error($sformatf("byte exp %02h last %0b, got %02h last %0b",
                               want.value, want.last, record_byte_o, last_byte_o));
        end
      end
    end
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 14);
  end

  initial begin
    reading_row_t row;
    directed_rows = '{
      '{32'd0, 16'h0000, 14'd0, 4'd10,
        {8'h0C, 8'h13, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h66, 8'h00, 8'h00, 40'h0}},
      '{32'd99999999, 16'h7FFF, 14'd3000, 4'd15,
        {8'h0C, 8'h13, 8'h99, 8'h99, 8'h99, 8'h99, 8'h02, 8'h66, 8'hFF, 8'h7F,
         8'h02, 8'hFD, 8'h46, 8'hB8, 8'h0B}},
      '{32'hFFFFFFFF, 16'h8000, 14'h3FFF, 4'd10,
        {8'h0C, 8'h13, 8'h95, 8'h72, 8'h96, 8'h94, 8'h02, 8'h66, 8'h00, 8'h80, 40'h0}},
      '{32'd100000000, 16'hFFFF, 14'd2500, 4'd10,
        {8'h0C, 8'h13, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h66, 8'hFF, 8'hFF, 40'h0}},
      '{32'd12345678, 16'h1234, 14'd2501, 4'd0, 120'h0},
      '{32'd1, 16'h00FF, 14'd5599, 4'd0, 120'h0},
      '{32'd87654321, 16'hFF00, 14'd5600, 4'd0, 120'h0},
      '{32'h80000000, 16'h5A5A, 14'h2AAA, 4'd0, 120'h0},
      '{32'h7FFFFFFF, 16'hA5A5, 14'h1555, 4'd0, 120'h0},
      '{32'd10, 16'h0001, 14'd5601, 4'd0, 120'h0}
    };
    floor_set   = '{14'd0, 14'h3FFF, 14'd3000, 14'd0, 14'h3FFE, 14'd0, 14'd0, 14'd100,
                    14'd2500};
    ceiling_set = '{14'h3FFF, 14'd0, 14'd3000, 14'd1, 14'h3FFF, 14'd0, 14'd0, 14'd200,
                    14'd5600};
    floor_set[5]   = 14'($urandom_range(0, 8000));
    ceiling_set[5] = 14'(floor_set[5] + $urandom_range(2, 8000));
    floor_set[6]   = 14'($urandom);
    ceiling_set[6] = 14'($urandom);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_DIRECTED; r++) send_reading(directed_rows[r]);
    wait_drained();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      write_limits(floor_set[p], ceiling_set[p]);
      quiet = (p == 3);
      for (int k = 0; k < PER_SETTING; k++) begin
        row = '0;
        case ($urandom_range(0, 4))
          0: row.vol = $urandom();
          1: row.vol = $urandom_range(0, 99999);
          2: row.vol = 32'd99999999 - $urandom_range(0, 20);
          3: row.vol = 32'd100000000 * $urandom_range(1, 42) + $urandom_range(0, 20);
          default: row.vol = 32'hFFFFFFFF - $urandom_range(0, 20);
        endcase
        case ($urandom_range(0, 7))
          0: row.temp = 16'h7FFF;
          1: row.temp = 16'h8000;
          2: row.temp = 16'h0000;
          3: row.temp = 16'hFFFF;
          default: row.temp = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0: row.sup = 14'(floor_mv - 14'd1);
          1: row.sup = floor_mv;
          2: row.sup = 14'(floor_mv + 14'd1);
          3: row.sup = 14'(ceiling_mv - 14'd1);
          4: row.sup = ceiling_mv;
          5: row.sup = 14'(ceiling_mv + 14'd1);
          6: row.sup = 14'd0;
          7: row.sup = 14'h3FFF;
          default: row.sup = 14'($urandom);
        endcase
        send_reading(row);
      end
      wait_drained();
    end
    quiet = 1'b0;

    repeat (60) @(posedge clk_i);
    $display("covered %0d readings over %0d limit settings, %0d with a supply record",
             readings_sent, NUM_SETTINGS + 1, supply_records);
    $display("%0d record bytes checked, %0d mismatches", bytes_seen, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
